// File: rtl/aes_bc_pkg.sv
package aes_bc_pkg;

    typedef logic [127:0]        t_block;
    typedef logic [255:0][7:0]   t_sbox;

    localparam int unsigned BLOCK_BYTES  = 16;
    localparam logic [3:0]  MIN_ROUNDS   = 4'd10;
    localparam logic        OP_KEY_WRITE = 1'b0;
    localparam logic        OP_BLOCK     = 1'b1;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                p = p ^ x;
            end
            x = x[7] ? ({x[6:0], 1'b0} ^ 8'h1b) : {x[6:0], 1'b0};
        end
        return p;
    endfunction

    function automatic logic [7:0] gf_inv(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] base;
        r = 8'h01;
        base = x;
        for (int i = 0; i < 8; i++) begin
            if (i != 0) begin
                r = gf_mul(r, base);
            end
            base = gf_mul(base, base);
        end
        return r;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    function automatic t_sbox make_sbox(input logic inverse);
        t_sbox t;
        logic [7:0] b;
        logic [7:0] y;
        for (int v = 0; v < 256; v++) begin
            b = 8'(v);
            if (inverse) begin
                y = rotl8(b, 1) ^ rotl8(b, 3) ^ rotl8(b, 6) ^ 8'h05;
                t[v] = gf_inv(y);
            end else begin
                y = gf_inv(b);
                t[v] = y ^ rotl8(y, 1) ^ rotl8(y, 2) ^ rotl8(y, 3) ^ rotl8(y, 4) ^ 8'h63;
            end
        end
        return t;
    endfunction

    localparam t_sbox SBOX     = make_sbox(1'b0);
    localparam t_sbox INV_SBOX = make_sbox(1'b1);

    function automatic t_block fwd_sub_shift(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[8*(4*c+r) +: 8] = SBOX[s[8*(4*((c+r)%4)+r) +: 8]];
            end
        end
        return t;
    endfunction

    function automatic t_block inv_sub_shift(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[8*(4*((c+r)%4)+r) +: 8] = INV_SBOX[s[8*(4*c+r) +: 8]];
            end
        end
        return t;
    endfunction

    function automatic t_block mix_columns(input t_block s, input logic inverse);
        t_block t;
        logic [3:0][7:0] m;
        logic [7:0] o;
        m = inverse ? {8'd9, 8'd13, 8'd11, 8'd14} : {8'd1, 8'd1, 8'd3, 8'd2};
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o = 8'h00;
                for (int k = 0; k < 4; k++) begin
                    o = o ^ gf_mul(m[(k-r+4)%4], s[8*(4*c+k) +: 8]);
                end
                t[8*(4*c+r) +: 8] = o;
            end
        end
        return t;
    endfunction

endpackage

// File: rtl/aes_bc_if.sv
interface aes_bc_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic        decrypt;
    logic [3:0]  key_index;
    logic [63:0] data_low;
    logic [63:0] data_high;

    modport source(output valid, operation, decrypt, key_index, data_low, data_high,
                   input ready);
    modport sink(input valid, operation, decrypt, key_index, data_low, data_high,
                 output ready);
endinterface

interface aes_bc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_low;
    logic [63:0] block_high;

    modport source(output valid, block_low, block_high, input ready);
    modport sink(input valid, block_low, block_high, output ready);
endinterface

// File: rtl/aes_bc_round.sv
module aes_bc_round #(
    parameter int unsigned ROUND = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [3:0]           i_nr,
    input  logic                 i_valid,
    input  logic                 i_dec,
    input  aes_bc_pkg::t_block   i_state,
    input  aes_bc_pkg::t_block   i_key,
    input  aes_bc_pkg::t_block   i_key_next,
    output logic                 o_valid,
    output logic                 o_dec,
    output aes_bc_pkg::t_block   o_state
);
    import aes_bc_pkg::*;

    localparam logic [4:0] RND = 5'(ROUND + 1);

    logic   r_valid;
    logic   r_dec;
    t_block r_state;
    t_block n_state;
    t_block s_key;
    t_block s_sub;

    always_comb begin
        s_key = i_state ^ i_key;
        s_sub = i_dec ? inv_sub_shift(s_key) : fwd_sub_shift(s_key);
        if (RND < {1'b0, i_nr}) begin
            n_state = mix_columns(s_sub, i_dec);
        end else if (RND == {1'b0, i_nr}) begin
            n_state = s_sub ^ i_key_next;
        end else begin
            n_state = i_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_dec   <= i_dec;
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;
    assign o_state = r_state;
endmodule

// File: rtl/aes_block_crypt.sv
// Each accepted block is registered, then passes the round stages, one round per stage.
// Throughput: one block transaction per cycle while the output side takes results.
// A key write transaction is taken only once the round pipeline holds no block.
// Reset is synchronous and active low; it clears the pipeline valid bits and sets
// round_count to 10. The round key table is undefined until written.
module aes_block_crypt #(
    parameter int unsigned MAX_ROUNDS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aes_bc_in_if.sink   i_in,
    aes_bc_out_if.source o_out,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data
);
    import aes_bc_pkg::*;

    logic [3:0]                 r_round_count;
    logic [3:0]                 s_nr;
    t_block [MAX_ROUNDS:0]      r_key;
    logic [MAX_ROUNDS:0]        s_valid;
    logic [MAX_ROUNDS:0]        s_dec;
    t_block [MAX_ROUNDS:0]      s_state;
    logic                       r_valid0;
    logic                       r_dec0;
    t_block                     r_state0;
    logic                       s_adv;
    logic                       s_accept;

    assign s_nr = (r_round_count < MIN_ROUNDS) ? MIN_ROUNDS :
                  (r_round_count > 4'(MAX_ROUNDS)) ? 4'(MAX_ROUNDS) : r_round_count;

    assign s_adv      = !s_valid[MAX_ROUNDS] || o_out.ready;
    assign i_in.ready = s_adv && ((i_in.operation == OP_BLOCK) || !(|s_valid));
    assign s_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_count <= MIN_ROUNDS;
            r_valid0      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_round_count <= i_cfg_data;
            end
            if (s_adv) begin
                r_valid0 <= s_accept && (i_in.operation == OP_BLOCK);
            end
        end
        if (s_adv) begin
            r_dec0   <= i_in.decrypt;
            r_state0 <= {i_in.data_high, i_in.data_low};
        end
        if (s_accept && (i_in.operation == OP_KEY_WRITE)
            && ({1'b0, i_in.key_index} <= 5'(MAX_ROUNDS))) begin
            r_key[i_in.key_index] <= {i_in.data_high, i_in.data_low};
        end
    end

    assign s_valid[0] = r_valid0;
    assign s_dec[0]   = r_dec0;
    assign s_state[0] = r_state0;

    for (genvar g = 0; g < MAX_ROUNDS; g++) begin : g_round
        aes_bc_round #(.ROUND(g)) u_round (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (s_adv),
            .i_nr       (s_nr),
            .i_valid    (s_valid[g]),
            .i_dec      (s_dec[g]),
            .i_state    (s_state[g]),
            .i_key      (r_key[g]),
            .i_key_next (r_key[g+1]),
            .o_valid    (s_valid[g+1]),
            .o_dec      (s_dec[g+1]),
            .o_state    (s_state[g+1])
        );
    end

    assign o_out.valid      = s_valid[MAX_ROUNDS];
    assign o_out.block_low  = s_state[MAX_ROUNDS][63:0];
    assign o_out.block_high = s_state[MAX_ROUNDS][127:64];
endmodule

// File: rtl/aes_bc_chk.sv
module aes_bc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_operation,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_low,
    input logic [63:0] i_out_high
);
    import aes_bc_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("Result valid after reset.");

    a_key_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_operation == OP_KEY_WRITE) |-> !i_out_valid)
        else $error("Key write transaction taken while results pending.");

    a_key_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_operation == OP_KEY_WRITE) |=> !i_out_valid)
        else $error("Key write transaction produced a result.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_low)
        && $stable(i_out_high))
        else $error("Stalled result changed.");
endmodule

bind aes_block_crypt aes_bc_chk u_aes_bc_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_operation (i_in.operation),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_low      (o_out.block_low),
    .i_out_high     (o_out.block_high)
);

// File: tb/aes_bc_checker.sv
`timescale 1ns / 100ps

module aes_bc_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    aes_bc_in_if  i_in,
    aes_bc_out_if i_out,
    input  logic  i_cfg_we,
    input  logic [3:0] i_cfg_data,
    output int    o_fail_count,
    output int    o_pending
);
    import aes_bc_pkg::*;

    logic [7:0]   fwd_table [256];
    logic [7:0]   inv_table [256];
    logic [127:0] key_slot [15];
    logic [3:0]   round_setting;
    t_block       expected_blocks [$];

    function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc ^= a;
            end
            a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
        end
        return acc;
    endfunction

    function automatic logic [7:0] field_inv(input logic [7:0] x);
        logic [7:0] acc;
        acc = 8'h01;
        for (int e = 0; e < 254; e++) begin
            acc = field_mul(acc, x);
        end
        return acc;
    endfunction

    function automatic logic [7:0] rot(input logic [7:0] x, input int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    function automatic t_block crypt_block(input t_block din, input logic dec,
                                           input logic [3:0] setting);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] col [4];
        logic [7:0] coef [4];
        logic [7:0] o;
        int nr;
        t_block res;
        nr = (setting < 10) ? 10 : ((setting > 14) ? 14 : int'(setting));
        if (dec) begin
            coef = '{8'd14, 8'd11, 8'd13, 8'd9};
        end else begin
            coef = '{8'd2, 8'd3, 8'd1, 8'd1};
        end
        for (int i = 0; i < 16; i++) begin
            s[i] = din[8*i +: 8];
        end
        for (int rnd = 0; rnd < nr; rnd++) begin
            for (int i = 0; i < 16; i++) begin
                s[i] ^= key_slot[rnd][8*i +: 8];
            end
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) begin
                    if (dec) begin
                        t[4*((c+r)%4)+r] = inv_table[s[4*c+r]];
                    end else begin
                        t[4*c+r] = fwd_table[s[4*((c+r)%4)+r]];
                    end
                end
            end
            s = t;
            if (rnd < nr - 1) begin
                for (int c = 0; c < 4; c++) begin
                    for (int r = 0; r < 4; r++) begin
                        col[r] = s[4*c+r];
                    end
                    for (int r = 0; r < 4; r++) begin
                        o = 8'h00;
                        for (int k = 0; k < 4; k++) begin
                            o ^= field_mul(coef[(k-r+4)%4], col[k]);
                        end
                        s[4*c+r] = o;
                    end
                end
            end
        end
        for (int i = 0; i < 16; i++) begin
            res[8*i +: 8] = s[i] ^ key_slot[nr][8*i +: 8];
        end
        return res;
    endfunction

    initial begin
        logic [7:0] b;
        for (int v = 0; v < 256; v++) begin
            b = field_inv(8'(v));
            fwd_table[v] = b ^ rot(b, 1) ^ rot(b, 2) ^ rot(b, 3) ^ rot(b, 4) ^ 8'h63;
            b = 8'(v);
            inv_table[v] = field_inv(rot(b, 1) ^ rot(b, 3) ^ rot(b, 6) ^ 8'h05);
        end
    end

    assign o_pending = expected_blocks.size();

    always @(posedge i_clk) begin
        t_block got;
        t_block want;
        if (!i_rst_n) begin
            round_setting <= 4'd10;
            o_fail_count  <= 0;
            expected_blocks.delete();
        end else begin
            if (i_cfg_we) begin
                round_setting <= i_cfg_data;
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.operation == OP_KEY_WRITE) begin
                    if (i_in.key_index <= 4'd14) begin
                        key_slot[i_in.key_index] <= {i_in.data_high, i_in.data_low};
                    end
                end else begin
                    expected_blocks.push_back(crypt_block({i_in.data_high, i_in.data_low},
                                                          i_in.decrypt, round_setting));
                end
            end
            if (i_out.valid && i_out.ready) begin
                got = {i_out.block_high, i_out.block_low};
                if (expected_blocks.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("unexpected result transaction %h", got);
                    end
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_blocks.pop_front();
                    if (got[63:0] !== want[63:0] || got[127:64] !== want[127:64]) begin
                        if (o_fail_count < 10) begin
                            $display("result mismatch: expected %h_%h, actual %h_%h",
                                     want[127:64], want[63:0], got[127:64], got[63:0]);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// File: tb/tb_aes_block_crypt.sv
`timescale 1ns / 100ps

module tb_aes_block_crypt;
    import aes_bc_pkg::*;

    localparam int STALL_LIMIT = 3000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [3:0] cfg_data;
    logic       idle_on;
    int         fail_count;
    int         pending;
    int         stall_cycles;

    aes_bc_in_if  u_in_ch();
    aes_bc_out_if u_out_ch();

    aes_block_crypt u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (u_in_ch),
        .o_out      (u_out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    aes_bc_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (u_in_ch),
        .i_out        (u_out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 65) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_item(input logic op, input logic dec, input logic [3:0] idx,
                             input logic [63:0] lo, input logic [63:0] hi);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            u_in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        u_in_ch.valid     = 1'b1;
        u_in_ch.operation = op;
        u_in_ch.decrypt   = dec;
        u_in_ch.key_index = idx;
        u_in_ch.data_low  = lo;
        u_in_ch.data_high = hi;
        do begin
            @(posedge clk);
        end while (!u_in_ch.ready);
        @(negedge clk);
    endtask

    task automatic drain_and_configure(input logic [3:0] value);
        u_in_ch.valid = 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic random_item();
        if ($urandom_range(0, 9) == 0) begin
            send_item(OP_KEY_WRITE, 1'($urandom), 4'($urandom), rand_word(), rand_word());
        end else begin
            send_item(OP_BLOCK, 1'($urandom), 4'($urandom), rand_word(), rand_word());
        end
    endtask

    always @(negedge clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 70) begin
            u_out_ch.ready <= 1'b1;
        end else if (r < 97) begin
            u_out_ch.ready <= 1'b0;
        end else begin
            u_out_ch.ready <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge clk) begin
        if ((u_in_ch.valid && u_in_ch.ready) || (u_out_ch.valid && u_out_ch.ready)
                || !rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [3:0] settings [9];
        settings = '{4'd12, 4'd14, 4'd0, 4'd11, 4'd13, 4'd15, 4'd9, 4'd10, 4'd14};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 4'd0;
        idle_on = 1'b0;
        stall_cycles = 0;
        u_in_ch.valid = 1'b0;
        u_in_ch.operation = OP_KEY_WRITE;
        u_in_ch.decrypt = 1'b0;
        u_in_ch.key_index = 4'd0;
        u_in_ch.data_low = 64'h0;
        u_in_ch.data_high = 64'h0;
        u_out_ch.ready = 1'b1;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        for (int k = 0; k < 15; k++) begin
            send_item(OP_KEY_WRITE, 1'(k), 4'(k), {$urandom, $urandom}, {$urandom, $urandom});
        end
        send_item(OP_KEY_WRITE, 1'b0, 4'd15, '1, '1);
        send_item(OP_BLOCK, 1'b0, 4'd0, 64'h0, 64'h0);
        send_item(OP_BLOCK, 1'b1, 4'd15, '1, '1);
        send_item(OP_BLOCK, 1'b0, 4'd7, 64'h0123456789abcdef, 64'hfedcba9876543210);
        send_item(OP_BLOCK, 1'b1, 4'd3, 64'h0, '1);
        send_item(OP_KEY_WRITE, 1'b1, 4'd10, 64'h0, '1);
        send_item(OP_BLOCK, 1'b0, 4'd0, '1, 64'h0);

        idle_on = 1'b1;
        for (int i = 0; i < 180; i++) begin
            random_item();
        end
        foreach (settings[p]) begin
            drain_and_configure(settings[p]);
            idle_on = (p % 3 != 0);
            for (int i = 0; i < 180; i++) begin
                random_item();
            end
        end
        u_in_ch.valid = 1'b0;

        for (int w = 0; w < 20000 && pending != 0; w++) begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// File: files.f
rtl/aes_bc_pkg.sv
rtl/aes_bc_if.sv
rtl/aes_bc_round.sv
rtl/aes_block_crypt.sv
rtl/aes_bc_chk.sv
tb/aes_bc_checker.sv
tb/tb_aes_block_crypt.sv
